// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the block's RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/mlnp_pkg.sv -----
// Package: sizes, codes, command and status types of the note allocator.
`default_nettype none

package mlnp_pkg;

  localparam int HELD_DEPTH   = 16;
  localparam int IDX_W        = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;
  localparam int CNT_W        = $clog2(HELD_DEPTH + 1);
  localparam int NOTE_W       = 7;
  localparam int REQ_W        = 2;
  localparam int ACT_W        = 2;
  localparam int HELD_COUNT_W = 5;
  localparam int OP_W         = 2;

  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
  localparam logic [CNT_W-1:0] HELD_FULL = CNT_W'(HELD_DEPTH);
  localparam logic [IDX_W-1:0] IDX_ONE   = IDX_W'(1);

  // Request codes on the input channel.
  localparam logic [REQ_W-1:0] REQ_ON   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_OFF  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_STOP = 2'd2;

  // Action codes on the result channel.
  localparam logic [ACT_W-1:0] ACT_NONE  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_START = 2'd1;
  localparam logic [ACT_W-1:0] ACT_STOP  = 2'd2;

  // Decoded operation of the latched item.
  localparam logic [OP_W-1:0] OP_ON   = 2'd0;
  localparam logic [OP_W-1:0] OP_OFF  = 2'd1;
  localparam logic [OP_W-1:0] OP_STOP = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic load;         // latch the input item
    logic scan_start;   // rewind the stack scan
    logic scan_run;     // advance the stack scan
    logic evict;        // scan drops the bottom entry instead of the matching note
    logic drop;         // shrink the count if the scan removed an entry
    logic push;         // push the note, start it and post the result
    logic off_commit;   // finish a note-off and post the result
    logic stop_commit;  // empty the stack and post the result
    logic none_commit;  // post a result with no action
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            scan_done;
    logic            full;
  } sts_t;

  function automatic logic [HELD_COUNT_W-1:0] count_out(input logic [CNT_W-1:0] c);
    logic [CNT_W+HELD_COUNT_W-1:0] w;
    w = {{HELD_COUNT_W{1'b0}}, c};
    return w[HELD_COUNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- hdl/mlnp_ctrl.sv -----
// Controller: sequences scan, evict, push and commit steps for each item.
`default_nettype none
`include "assert_macros.svh"

module mlnp_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output mlnp_pkg::cmd_t     cmd,
  input  wire mlnp_pkg::sts_t sts
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_SCAN     = 3'd2;
  localparam logic [2:0] S_FULL     = 3'd3;
  localparam logic [2:0] S_EVICT    = 3'd4;
  localparam logic [2:0] S_PUSH     = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;
  logic       commit;

  assign slot_free = !out_valid_r || out_ready;
  assign commit    = cmd.push || cmd.off_commit || cmd.stop_commit || cmd.none_commit;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.op)
          mlnp_pkg::OP_ON, mlnp_pkg::OP_OFF: begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end
          mlnp_pkg::OP_STOP: begin
            if (slot_free) begin
              cmd.stop_commit = 1'b1;
              state_nxt       = S_IDLE;
            end
          end
          default: begin
            if (slot_free) begin
              cmd.none_commit = 1'b1;
              state_nxt       = S_IDLE;
            end
          end
        endcase
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_done) begin
          if (sts.op == mlnp_pkg::OP_OFF) begin
            if (slot_free) begin
              cmd.off_commit = 1'b1;
              state_nxt      = S_IDLE;
            end
          end else begin
            cmd.drop  = 1'b1;
            state_nxt = S_FULL;
          end
        end
      end
      S_FULL: begin
        if (sts.full) begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_EVICT;
        end else begin
          state_nxt = S_PUSH;
        end
      end
      S_EVICT: begin
        cmd.scan_run = 1'b1;
        cmd.evict    = 1'b1;
        if (sts.scan_done) begin
          cmd.drop  = 1'b1;
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (slot_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `ASSERT_IMPL(a_commit_slot, commit, slot_free, "result posted over an untaken result")
  `ASSERT_IMPL(a_one_commit, 1'b1,
    $onehot0({cmd.push, cmd.off_commit, cmd.stop_commit, cmd.none_commit}),
    "more than one commit in a cycle")
  `ASSERT_NEXT(a_commit_valid, commit, out_valid_r, "posted result not presented")

endmodule

`default_nettype wire

// ----- hdl/mlnp_dp.sv -----
// Datapath: held-note stack memory, scan engine, voice state and result register.
`default_nettype none
`include "assert_macros.svh"

module mlnp_dp (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire mlnp_pkg::cmd_t                      cmd,
  output mlnp_pkg::sts_t                           sts,
  input  wire logic [mlnp_pkg::REQ_W-1:0]          in_req_type,
  input  wire logic [mlnp_pkg::NOTE_W-1:0]         in_note,
  input  wire logic [mlnp_pkg::NOTE_W-1:0]         in_velocity,
  output logic      [mlnp_pkg::ACT_W-1:0]          out_action,
  output logic      [mlnp_pkg::NOTE_W-1:0]         out_action_note,
  output logic                                     out_sounding,
  output logic      [mlnp_pkg::NOTE_W-1:0]         out_current_note,
  output logic      [mlnp_pkg::HELD_COUNT_W-1:0]   out_held_count
);

  // Held-note stack, oldest at index 0.
  logic [mlnp_pkg::NOTE_W-1:0] stack_mem [mlnp_pkg::HELD_DEPTH];

  logic [mlnp_pkg::REQ_W-1:0]  req_r;
  logic [mlnp_pkg::NOTE_W-1:0] note_r;
  logic                        vel_zero_r;

  logic [mlnp_pkg::CNT_W-1:0]  total_r, total_nxt;
  logic [mlnp_pkg::NOTE_W-1:0] active_r, active_nxt;
  logic                        flag_r, flag_nxt;

  logic [mlnp_pkg::CNT_W-1:0]  rd_idx_r;
  logic                        pend_r;
  logic [mlnp_pkg::IDX_W-1:0]  pend_idx_r;
  logic                        found_r;
  logic [mlnp_pkg::NOTE_W-1:0] top_r;
  logic [mlnp_pkg::NOTE_W-1:0] rdata_r;

  logic [mlnp_pkg::ACT_W-1:0]        action_r;
  logic [mlnp_pkg::NOTE_W-1:0]       action_note_r;
  logic                              sounding_r;
  logic [mlnp_pkg::NOTE_W-1:0]       current_note_r;
  logic [mlnp_pkg::HELD_COUNT_W-1:0] held_count_r;

  logic [mlnp_pkg::OP_W-1:0]   op;
  logic                        issue;
  logic                        hit;
  logic                        wr_en;
  logic [mlnp_pkg::IDX_W-1:0]  wr_addr;
  logic [mlnp_pkg::NOTE_W-1:0] wr_data;
  logic                        res_valid;
  logic [mlnp_pkg::ACT_W-1:0]  act;
  logic [mlnp_pkg::NOTE_W-1:0] act_note;

  always_comb begin
    case (req_r)
      mlnp_pkg::REQ_ON:   op = vel_zero_r ? mlnp_pkg::OP_OFF : mlnp_pkg::OP_ON;
      mlnp_pkg::REQ_OFF:  op = mlnp_pkg::OP_OFF;
      mlnp_pkg::REQ_STOP: op = mlnp_pkg::OP_STOP;
      default:            op = mlnp_pkg::OP_NONE;
    endcase
  end

  assign issue = (rd_idx_r < total_r);
  assign hit   = cmd.evict ? (pend_idx_r == '0) : (rdata_r == note_r);

  assign sts.op        = op;
  assign sts.scan_done = !issue && !pend_r;
  assign sts.full      = (total_r == mlnp_pkg::HELD_FULL);

  // Compaction write: entries past the removed one move down by one.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pend_idx_r - mlnp_pkg::IDX_ONE;
    wr_data = rdata_r;
    if (cmd.push) begin
      wr_en   = 1'b1;
      wr_addr = total_r[mlnp_pkg::IDX_W-1:0];
      wr_data = note_r;
    end else if (cmd.scan_run && pend_r && found_r) begin
      wr_en = 1'b1;
    end
  end

  always_comb begin
    total_nxt  = total_r;
    active_nxt = active_r;
    flag_nxt   = flag_r;
    act        = mlnp_pkg::ACT_NONE;
    act_note   = '0;
    res_valid  = cmd.push || cmd.off_commit || cmd.stop_commit || cmd.none_commit;
    if (cmd.drop && found_r) begin
      total_nxt = total_r - mlnp_pkg::CNT_ONE;
    end
    if (cmd.push) begin
      total_nxt  = total_r + mlnp_pkg::CNT_ONE;
      active_nxt = note_r;
      flag_nxt   = 1'b1;
      act        = mlnp_pkg::ACT_START;
      act_note   = note_r;
    end
    if (cmd.off_commit && found_r) begin
      total_nxt = total_r - mlnp_pkg::CNT_ONE;
      if (flag_r && (active_r == note_r)) begin
        if (total_r == mlnp_pkg::CNT_ONE) begin
          flag_nxt = 1'b0;
          act      = mlnp_pkg::ACT_STOP;
          act_note = note_r;
        end else begin
          // Restart the newest remaining note.
          active_nxt = top_r;
          act        = mlnp_pkg::ACT_START;
          act_note   = top_r;
        end
      end
    end
    if (cmd.stop_commit) begin
      total_nxt = '0;
      flag_nxt  = 1'b0;
      if (flag_r) begin
        act      = mlnp_pkg::ACT_STOP;
        act_note = active_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    rdata_r <= stack_mem[rd_idx_r[mlnp_pkg::IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r  <= '0;
      active_r <= '0;
      flag_r   <= 1'b0;
      rd_idx_r <= '0;
      pend_r   <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      total_r  <= total_nxt;
      active_r <= active_nxt;
      flag_r   <= flag_nxt;
      if (cmd.scan_start) begin
        rd_idx_r <= '0;
        pend_r   <= 1'b0;
        found_r  <= 1'b0;
      end else if (cmd.scan_run) begin
        pend_r <= issue;
        if (issue) begin
          rd_idx_r <= rd_idx_r + mlnp_pkg::CNT_ONE;
        end
        if (pend_r && !found_r && hit) begin
          found_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r      <= in_req_type;
      note_r     <= in_note;
      vel_zero_r <= (in_velocity == '0);
    end
    if (cmd.scan_run) begin
      pend_idx_r <= rd_idx_r[mlnp_pkg::IDX_W-1:0];
      // Track the newest entry that stays in the stack.
      if (pend_r && (found_r || !hit)) begin
        top_r <= rdata_r;
      end
    end
    if (res_valid) begin
      action_r       <= act;
      action_note_r  <= act_note;
      sounding_r     <= flag_nxt;
      current_note_r <= active_nxt;
      held_count_r   <= mlnp_pkg::count_out(total_nxt);
    end
  end

  assign out_action       = action_r;
  assign out_action_note  = action_note_r;
  assign out_sounding     = sounding_r;
  assign out_current_note = current_note_r;
  assign out_held_count   = held_count_r;

  `ASSERT_IMPL(a_sound_held, res_valid && flag_nxt, total_nxt != '0,
    "note sounding with empty stack")
  `ASSERT_IMPL(a_count_max, 1'b1, total_r <= mlnp_pkg::HELD_FULL, "held count beyond depth")
  `ASSERT_IMPL(a_shift_addr, cmd.scan_run && pend_r && found_r, pend_idx_r != '0,
    "compaction write below the bottom entry")
  `ASSERT_NEXT(a_stop_empty, cmd.stop_commit, total_r == '0 && !flag_r,
    "stop-all left notes held")

endmodule

`default_nettype wire

// ----- hdl/mono_last_note_priority_top.sv -----
// Top level: monophonic last-note-priority voice allocator.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one MIDI event per item:
//   in_req_type (0 note on, 1 note off, 2 stop all), in_note, in_velocity.
//   A note-on with zero velocity is handled as a note-off.
//   Result channel (out_valid/out_ready) returns exactly one item per event:
//   the action (none, start, stop), its note, and the voice state after the
//   event (sounding flag, current note, number of held notes).
//   Timing: one item is processed at a time. Stop-all and unknown requests post
//   their result straight from dispatch; a note-off scans the held stack
//   and then posts; a note-on scans the stack, rescans it to evict the oldest
//   note when the stack is full, then pushes the note and posts. The
//   scan reads one entry per cycle while compaction writes on a second port.
//   A new event is accepted only after the previous result is posted.
//   Reset: the stack is emptied and no note sounds; stack contents are not
//   cleared, since only entries below the held count are ever read.
//   Stall: the result register holds an untaken item; a new event is still
//   accepted and processed, and its result waits until the slot frees.
`default_nettype none

module mono_last_note_priority_top (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [mlnp_pkg::REQ_W-1:0]          in_req_type,
  input  wire logic [mlnp_pkg::NOTE_W-1:0]         in_note,
  input  wire logic [mlnp_pkg::NOTE_W-1:0]         in_velocity,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic      [mlnp_pkg::ACT_W-1:0]          out_action,
  output logic      [mlnp_pkg::NOTE_W-1:0]         out_action_note,
  output logic                                     out_sounding,
  output logic      [mlnp_pkg::NOTE_W-1:0]         out_current_note,
  output logic      [mlnp_pkg::HELD_COUNT_W-1:0]   out_held_count
);

  // Command and status between sequencer and datapath.
  mlnp_pkg::cmd_t cmd;
  mlnp_pkg::sts_t sts;

  // Sequence each event: latch, scan, evict, push, post the result.
  mlnp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Hold the stack, the voice state and the result register.
  mlnp_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_req_type      (in_req_type),
    .in_note          (in_note),
    .in_velocity      (in_velocity),
    .out_action       (out_action),
    .out_action_note  (out_action_note),
    .out_sounding     (out_sounding),
    .out_current_note (out_current_note),
    .out_held_count   (out_held_count)
  );

endmodule

`default_nettype wire
